[design/kvi_pkg.sv]
package kvi_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned ValW   = 32;
    localparam int unsigned FracW  = 16;
    localparam int unsigned RatioW = FracW + 1;
    localparam int unsigned DiffW  = ValW + 1;
    localparam int unsigned ProdW  = DiffW + RatioW + 1;
    localparam int unsigned RoundW = ProdW - FracW;
    localparam int unsigned SumW   = RoundW + 1;

    // One quotient bit is resolved per divider stage.
    localparam int unsigned DivSteps = FracW;

    // Accept edge to the edge that takes the result: input stage, divider,
    // multiplier, rounding and output register.
    localparam int unsigned PipeLatency = DivSteps + 4;

    localparam logic [RatioW-1:0] RatioOne = RatioW'(1) << FracW;

    localparam logic signed [ProdW-1:0] RoundBias = ProdW'(1) << (FracW - 1);

    // Half and full turns in Q16.16.
    localparam logic signed [DiffW-1:0] RadHalf = DiffW'(205887);
    localparam logic signed [DiffW-1:0] RadFull = DiffW'(411775);
    localparam logic signed [DiffW-1:0] DegHalf = DiffW'(11796480);
    localparam logic signed [DiffW-1:0] DegFull = DiffW'(23592960);

    typedef enum logic [1:0] {
        MODE_DISCRETE = 2'd0,
        MODE_LINEAR   = 2'd1,
        MODE_RADIANS  = 2'd2,
        MODE_DEGREES  = 2'd3
    } t_interp_mode;

    // Item data that rides alongside the divider.
    typedef struct packed {
        logic [DiffW-1:0] diff;
        logic [ValW-1:0]  v1;
        logic [ValW-1:0]  v2;
        logic             blend;
        logic             full;
        logic             past_end;
    } t_side;

endpackage

[design/keyframe_value_interpolator_unit.sv]
// Keyframe value interpolator.
// Input channel: a word is taken at each rising edge where start is high and
// busy is low. busy never rises, so a new word may be offered every cycle.
// The word carries a query time, the times of the earlier and later
// keyframes, both Q16.16 values, the interpolation mode and the real flag.
// Result channel: o_valid is high for exactly one cycle with the blended
// value, the Q1.16 ratio used and the past-end flag. The receiver cannot
// stall this channel and must take every word as it comes.
// Pipeline: one input stage, sixteen divider stages that each resolve one
// quotient bit, one multiplier stage, one rounding stage and the output
// register.
// Throughput is one word per cycle.
// Configuration: i_cfg_we writes i_cfg_wdata into the tape duration, which
// is compared with the query time as a word enters.
// Reset (synchronous, active low) empties the pipeline and sets the tape
// duration to all ones; words in flight are dropped.
module keyframe_value_interpolator_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kvi_pkg::TimeW-1:0]        i_cfg_wdata,
    input  logic                             start,
    output logic                             busy,
    input  logic [kvi_pkg::TimeW-1:0]        i_query_time,
    input  logic [kvi_pkg::TimeW-1:0]        i_prev_key_time,
    input  logic [kvi_pkg::TimeW-1:0]        i_next_key_time,
    input  logic                             i_has_prev,
    input  logic signed [kvi_pkg::ValW-1:0]  i_earlier_value,
    input  logic signed [kvi_pkg::ValW-1:0]  i_later_value,
    input  logic [1:0]                       i_interp_mode,
    input  logic                             i_signal_is_real,
    output logic                             o_valid,
    output logic signed [kvi_pkg::ValW-1:0]  o_interp_value,
    output logic [kvi_pkg::RatioW-1:0]       o_blend_ratio,
    output logic                             o_past_end
);
    import kvi_pkg::*;

    logic                 accept;
    logic [TimeW-1:0]     r_tape_duration;

    logic [DivSteps:0]    r_vld;
    logic [TimeW-1:0]     r_rem  [0:DivSteps-1];
    logic [TimeW-1:0]     r_gap  [0:DivSteps-1];
    logic [FracW-1:0]     r_quo  [0:DivSteps];
    t_side                r_side [0:DivSteps];
    t_interp_mode         r_mode0;

    logic [TimeW:0]       n_dbl [0:DivSteps-1];
    logic [TimeW:0]       n_sub [0:DivSteps-1];
    logic                 n_ge  [0:DivSteps-1];

    t_side                n_side1;
    logic signed [DiffW-1:0] n_diff;
    logic signed [DiffW-1:0] n_half;
    logic signed [DiffW-1:0] n_turn;
    logic                 n_wrap;

    logic [RatioW-1:0]    n_ratio;
    logic signed [ProdW-1:0] n_prod;
    logic                 r_m_vld;
    logic signed [ProdW-1:0] r_m_prod;
    logic [RatioW-1:0]    r_m_ratio;
    logic [ValW-1:0]      r_m_v1;
    logic [ValW-1:0]      r_m_v2;
    logic                 r_m_blend;
    logic                 r_m_past;

    logic signed [ProdW-1:0] n_round;
    logic                 r_r_vld;
    logic [RoundW-1:0]    r_r_q;
    logic [RatioW-1:0]    r_r_ratio;
    logic [ValW-1:0]      r_r_v1;
    logic [ValW-1:0]      r_r_v2;
    logic                 r_r_blend;
    logic                 r_r_past;

    logic [SumW-1:0]      n_sum;
    logic [ValW-1:0]      n_value;

    logic                 r_out_valid;
    logic [ValW-1:0]      r_out_value;
    logic [RatioW-1:0]    r_out_ratio;
    logic                 r_out_past;

    // The pipeline never stalls, so a word is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Control: configuration register and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tape_duration <= '1;
            r_vld           <= '0;
            r_m_vld         <= 1'b0;
            r_r_vld         <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tape_duration <= i_cfg_wdata;
            end
            r_vld       <= {r_vld[DivSteps-1:0], accept};
            r_m_vld     <= r_vld[DivSteps];
            r_r_vld     <= r_m_vld;
            r_out_valid <= r_r_vld;
        end
    end

    // One restoring division step per stage. The remainder stays below the
    // gap, so the doubled remainder fits one extra bit.
    always_comb begin
        for (int k = 0; k < DivSteps; k++) begin
            n_dbl[k] = {r_rem[k], 1'b0};
            n_ge[k]  = n_dbl[k] >= {1'b0, r_gap[k]};
            n_sub[k] = n_dbl[k] - {1'b0, r_gap[k]};
        end
    end

    // Angle wrap runs beside the first division step.
    always_comb begin
        n_side1 = r_side[0];
        n_diff  = $signed(r_side[0].diff);
        n_half  = '0;
        n_turn  = '0;
        n_wrap  = 1'b0;
        unique case (r_mode0) inside
            MODE_RADIANS: begin
                n_half = RadHalf;
                n_turn = RadFull;
                n_wrap = 1'b1;
            end
            MODE_DEGREES: begin
                n_half = DegHalf;
                n_turn = DegFull;
                n_wrap = 1'b1;
            end
            MODE_DISCRETE, MODE_LINEAR: begin
                n_wrap = 1'b0;
            end
            default: begin
                n_wrap = 1'b0;
            end
        endcase
        if (n_wrap && (n_diff > n_half)) begin
            n_side1.diff = n_diff - n_turn;
        end else if (n_wrap && (n_diff < -n_half)) begin
            n_side1.diff = n_diff + n_turn;
        end
    end

    // Data path: input stage and divider stages.
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= i_query_time - i_prev_key_time;
        r_gap[0]  <= i_next_key_time - i_prev_key_time;
        r_quo[0]  <= '0;
        r_mode0   <= t_interp_mode'(i_interp_mode);
        r_side[0] <= '{
            diff:     {i_later_value[ValW-1], i_later_value}
                      - {i_earlier_value[ValW-1], i_earlier_value},
            v1:       i_earlier_value,
            v2:       i_later_value,
            blend:    i_has_prev && i_signal_is_real
                      && (t_interp_mode'(i_interp_mode) != MODE_DISCRETE),
            full:     !(i_has_prev && (i_query_time > i_prev_key_time)
                        && (i_query_time < i_next_key_time)),
            past_end: i_query_time > r_tape_duration
        };
        r_side[1] <= n_side1;
        for (int k = 0; k < DivSteps; k++) begin
            if (k < DivSteps - 1) begin
                r_rem[k+1] <= n_ge[k] ? n_sub[k][TimeW-1:0] : n_dbl[k][TimeW-1:0];
                r_gap[k+1] <= r_gap[k];
            end
            r_quo[k+1] <= {r_quo[k][FracW-2:0], n_ge[k]};
            if (k > 0) begin
                r_side[k+1] <= r_side[k];
            end
        end
    end

    // Multiplier stage.
    always_comb begin
        n_ratio = r_side[DivSteps].full ? RatioOne : {1'b0, r_quo[DivSteps]};
        n_prod  = $signed(r_side[DivSteps].diff) * $signed({1'b0, n_ratio});
    end

    // Rounding: add one half, then an arithmetic shift gives the floor.
    assign n_round = r_m_prod + RoundBias;

    // Final add with saturation to the signed range; unblended, the later value.
    always_comb begin
        n_sum = {{(SumW-ValW){r_r_v1[ValW-1]}}, r_r_v1}
              + {{(SumW-RoundW){r_r_q[RoundW-1]}}, r_r_q};
        if (n_sum[SumW-1] && !(&n_sum[SumW-2:ValW-1])) begin
            n_value = {1'b1, {(ValW-1){1'b0}}};
        end else if (!n_sum[SumW-1] && (|n_sum[SumW-2:ValW-1])) begin
            n_value = {1'b0, {(ValW-1){1'b1}}};
        end else begin
            n_value = n_sum[ValW-1:0];
        end
        if (!r_r_blend) begin
            n_value = r_r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_prod    <= n_prod;
        r_m_ratio   <= n_ratio;
        r_m_v1      <= r_side[DivSteps].v1;
        r_m_v2      <= r_side[DivSteps].v2;
        r_m_blend   <= r_side[DivSteps].blend;
        r_m_past    <= r_side[DivSteps].past_end;

        r_r_q       <= n_round[ProdW-1:FracW];
        r_r_ratio   <= r_m_ratio;
        r_r_v1      <= r_m_v1;
        r_r_v2      <= r_m_v2;
        r_r_blend   <= r_m_blend;
        r_r_past    <= r_m_past;

        r_out_value <= n_value;
        r_out_ratio <= r_r_ratio;
        r_out_past  <= r_r_past;
    end

    assign o_valid        = r_out_valid;
    assign o_interp_value = r_out_value;
    assign o_blend_ratio  = r_out_ratio;
    assign o_past_end     = r_out_past;

endmodule

[design/kvi_checker.sv]
module kvi_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             i_has_prev,
    input logic                             i_signal_is_real,
    input logic signed [kvi_pkg::ValW-1:0]  i_later_value,
    input logic                             o_valid,
    input logic signed [kvi_pkg::ValW-1:0]  o_interp_value,
    input logic [kvi_pkg::RatioW-1:0]       o_blend_ratio
);
    import kvi_pkg::*;

    // Every accepted word yields exactly one result after the fixed latency.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PipeLatency o_valid)
        else $error("accepted word produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##PipeLatency !o_valid)
        else $error("result without an accepted word");

    // Without an earlier keyframe the ratio is one.
    a_ratio_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_has_prev) |-> ##PipeLatency (o_blend_ratio == RatioOne))
        else $error("ratio not one without earlier keyframe");

    // Integer signals pass the later value unchanged.
    a_int_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_signal_is_real) |-> ##PipeLatency
        (o_interp_value == $past(i_later_value, PipeLatency)))
        else $error("integer signal did not take the later value");

endmodule

bind keyframe_value_interpolator_unit kvi_checker u_kvi_checker (.*);
